### sv/vmrt_pkg.sv
// Shared constants, codes and types of the virtual-memory region table.
// Used by vmrt_ctrl, vmrt_dp and vm_region_table_unit; depends on nothing.
`default_nettype none

package vmrt_pkg;

    // Table geometry and page size.
    localparam int REGION_SLOTS = 16;
    localparam int PAGE_BITS    = 12;

    localparam int ADDR_W  = 64;
    localparam int HI_W    = ADDR_W - PAGE_BITS;
    localparam int SLOT_IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_W   = $clog2(REGION_SLOTS + 1);

    localparam logic [ADDR_W-1:0] USER_LIMIT = 64'h0000_8000_0000_0000;
    localparam logic [ADDR_W-1:0] BASE_RESET = 64'h0000_0020_0000_0000;

    // Command codes of the input word.
    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_FIND    = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_RESERVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_REJECTED  = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    // State changes applied when a command completes.
    typedef logic [2:0] act_t;

    localparam act_t ACT_NONE   = 3'd0;
    localparam act_t ACT_WRITE  = 3'd1;
    localparam act_t ACT_REMOVE = 3'd2;
    localparam act_t ACT_BUMP   = 3'd3;
    localparam act_t ACT_CLEAR  = 3'd4;

    // Source of the result fields.
    typedef logic [1:0] sel_t;

    localparam sel_t SEL_NONE    = 2'd0;
    localparam sel_t SEL_ADD     = 2'd1;
    localparam sel_t SEL_FOUND   = 2'd2;
    localparam sel_t SEL_RESERVE = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [2:0]        prot;
        logic [11:0]       flags;
        logic [10:0]       fdesc;
        logic [47:0]       foffset;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    prep1;
        logic    prep2;
        logic    scan_init;
        logic    scan;
        logic    finish;
        status_t status;
        act_t    act;
        sel_t    sel;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       len_zero;
        logic       len_ok;
        logic       carry;
        logic       base_wrap;
        logic       e_ge_limit;
        logic       clash;
        logic       free_found;
        logic       found;
        logic       scan_done;
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/vm_region_table_unit.sv
// Top level of the virtual-memory region table.
// Instantiates vmrt_ctrl and vmrt_dp; uses vmrt_pkg.
`default_nettype none

// The unit keeps a table of up to REGION_SLOTS page-aligned regions and a bump
// pointer for reserving address space. Each input word carries one command: add,
// find, remove, reserve or clear. Exactly one result word comes back for every
// input word, in order, with a status and, where an add, find or reserve
// succeeds, the region or reserved base. Words are moved with valid and stall on
// both sides. The unit works on one command at a time: a command passes through
// the accept state, the alignment states (page rounding, then the end-address
// add) and a completion state. Add, find and remove also scan the table one slot
// per cycle through a single shared comparator set before completion; add scans
// every slot, while find and remove stop after the first match. A finished
// result sits in the output register while the next word is already accepted
// and processed; only completion waits for the result to be taken. Reset
// empties the table and restores the mapping base at once; no clearing pass is
// needed.
module vm_region_table_unit
    import vmrt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         command,
    input  wire logic [ADDR_W-1:0]  address,
    input  wire logic [ADDR_W-1:0]  length,
    input  wire logic [2:0]         protection,
    input  wire logic [11:0]        region_flags,
    input  wire logic signed [10:0] file_desc,
    input  wire logic [47:0]        file_offset,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [ADDR_W-1:0]       result_address,
    output logic [ADDR_W-1:0]       result_end,
    output logic [2:0]              result_protection,
    output logic [11:0]             result_region_flags,
    output logic signed [10:0]      result_file_desc,
    output logic [47:0]             result_file_offset
);

    // Command and status between the sequencer and the datapath.
    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    vmrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dp_stat),
        .cmd_o     (ctrl_cmd)
    );

    // The datapath holds the table, the mapping base and the result register.
    vmrt_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (ctrl_cmd),
        .stat                (dp_stat),
        .command             (command),
        .address             (address),
        .length              (length),
        .protection          (protection),
        .region_flags        (region_flags),
        .file_desc           (file_desc),
        .file_offset         (file_offset),
        .status              (status),
        .result_address      (result_address),
        .result_end          (result_end),
        .result_protection   (result_protection),
        .result_region_flags (result_region_flags),
        .result_file_desc    (result_file_desc),
        .result_file_offset  (result_file_offset)
    );

endmodule

`default_nettype wire

### sv/vmrt_dp.sv
// Datapath of the region table: input word latch, page alignment, slot scan,
// region storage, mapping base and result registers. Uses vmrt_pkg.
`default_nettype none

module vmrt_dp
    import vmrt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_cmd_t          cmd,
    output dp_stat_t                stat,
    input  wire logic [2:0]         command,
    input  wire logic [ADDR_W-1:0]  address,
    input  wire logic [ADDR_W-1:0]  length,
    input  wire logic [2:0]         protection,
    input  wire logic [11:0]        region_flags,
    input  wire logic signed [10:0] file_desc,
    input  wire logic [47:0]        file_offset,
    output logic [1:0]              status,
    output logic [ADDR_W-1:0]       result_address,
    output logic [ADDR_W-1:0]       result_end,
    output logic [2:0]              result_protection,
    output logic [11:0]             result_region_flags,
    output logic signed [10:0]      result_file_desc,
    output logic [47:0]             result_file_offset
);

    // Latched input word.
    logic [2:0]        cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [2:0]        prot_reg;
    logic [11:0]       flags_reg;
    logic [10:0]       fdesc_reg;
    logic [47:0]       foffset_reg;

    // Alignment results.
    logic [ADDR_W-1:0] s_reg, s_next;
    logic [HI_W-1:0]   al_reg, al_next;
    logic              len_ok_reg, len_zero_reg, base_wrap_reg;
    logic [ADDR_W-1:0] e_reg;
    logic              carry_reg;

    logic [HI_W-1:0]   len_hi_round;
    logic [HI_W:0]     base_sum;
    logic              len_zero_now;
    logic [ADDR_W:0]   end_sum;

    // Table storage and mapping base.
    entry_t                  ent_mem [REGION_SLOTS];
    logic [REGION_SLOTS-1:0] valid_reg;
    logic [ADDR_W-1:0]       mb_reg;

    // Scan state.
    logic [CNT_W-1:0]   idx_reg;
    logic [SLOT_IW-1:0] slot_idx;
    logic               in_range;
    logic               scan_done;
    logic               clash_reg, free_found_reg, found_reg;
    logic [SLOT_IW-1:0] free_idx_reg, match_idx_reg;
    entry_t             hit_ent_reg;

    entry_t cur_ent;
    logic   cur_vld;
    logic   e_le_start, s_ge_end, s_ge_start, exact;
    logic   hit_now, clash_now;

    entry_t new_ent;

    // Page rounding of the length, and of the mapping base for reserve.
    assign len_zero_now = (len_reg == '0);
    assign len_hi_round = len_reg[ADDR_W-1:PAGE_BITS]
                        + HI_W'(|len_reg[PAGE_BITS-1:0]);
    assign base_sum     = {1'b0, mb_reg[ADDR_W-1:PAGE_BITS]}
                        + (HI_W+1)'(|mb_reg[PAGE_BITS-1:0]);

    always_comb
    begin
        if (cmd_reg == CMD_RESERVE)
        begin
            s_next = {base_sum[HI_W-1:0], {PAGE_BITS{1'b0}}};
        end
        else
        begin
            s_next = {addr_reg[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
        end
        if (cmd_reg == CMD_RESERVE && len_zero_now)
        begin
            al_next = HI_W'(1);
        end
        else
        begin
            al_next = len_hi_round;
        end
    end

    assign end_sum = {1'b0, s_reg} + {1'b0, al_reg, {PAGE_BITS{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= command;
            addr_reg    <= address;
            len_reg     <= length;
            prot_reg    <= protection;
            flags_reg   <= region_flags;
            fdesc_reg   <= file_desc;
            foffset_reg <= file_offset;
        end
        if (cmd.prep1)
        begin
            s_reg         <= s_next;
            al_reg        <= al_next;
            len_zero_reg  <= len_zero_now;
            // The length rounds up to whole pages without passing 2^64 unless
            // every page bit is set and a partial page remains.
            len_ok_reg    <= !(&len_reg[ADDR_W-1:PAGE_BITS] && |len_reg[PAGE_BITS-1:0]);
            base_wrap_reg <= base_sum[HI_W];
        end
        if (cmd.prep2)
        begin
            e_reg     <= end_sum[ADDR_W-1:0];
            carry_reg <= end_sum[ADDR_W];
        end
    end

    // One slot is examined per cycle.
    assign slot_idx  = idx_reg[SLOT_IW-1:0];
    assign in_range  = (idx_reg < CNT_W'(REGION_SLOTS));
    assign scan_done = found_reg || !in_range;
    assign cur_ent   = ent_mem[slot_idx];
    assign cur_vld   = valid_reg[slot_idx];

    assign e_le_start = (e_reg <= cur_ent.start_addr);
    assign s_ge_end   = (s_reg >= cur_ent.end_addr);
    assign s_ge_start = (s_reg >= cur_ent.start_addr);
    assign exact      = (s_reg == cur_ent.start_addr) && (e_reg == cur_ent.end_addr);
    assign clash_now  = cur_vld && !(e_le_start || s_ge_end);

    always_comb
    begin
        case (cmd_reg)
            CMD_FIND:   hit_now = cur_vld && s_ge_start && !s_ge_end;
            CMD_REMOVE: hit_now = cur_vld && exact;
            default:    hit_now = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            clash_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            idx_reg        <= '0;
            clash_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (cmd.scan && !scan_done)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (clash_now)
            begin
                clash_reg <= 1'b1;
            end
            if (!cur_vld && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (hit_now)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && !scan_done)
        begin
            if (!cur_vld && !free_found_reg)
            begin
                free_idx_reg <= slot_idx;
            end
            if (hit_now)
            begin
                match_idx_reg <= slot_idx;
                hit_ent_reg   <= cur_ent;
            end
        end
    end

    // Region storage: valid bits and mapping base are reset, entries are not.
    assign new_ent = '{start_addr: s_reg, end_addr: e_reg, prot: prot_reg,
                       flags: flags_reg, fdesc: fdesc_reg, foffset: foffset_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.finish && cmd.act == ACT_WRITE)
        begin
            ent_mem[free_idx_reg] <= new_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mb_reg    <= BASE_RESET;
        end
        else if (cmd.finish)
        begin
            case (cmd.act)
                ACT_WRITE:  valid_reg[free_idx_reg]  <= 1'b1;
                ACT_REMOVE: valid_reg[match_idx_reg] <= 1'b0;
                ACT_BUMP:   mb_reg <= e_reg;
                ACT_CLEAR:
                begin
                    valid_reg <= '0;
                    mb_reg    <= BASE_RESET;
                end
                default:    ;
            endcase
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status              <= cmd.status;
            result_address      <= '0;
            result_end          <= '0;
            result_protection   <= '0;
            result_region_flags <= '0;
            result_file_desc    <= '0;
            result_file_offset  <= '0;
            case (cmd.sel)
                SEL_ADD:
                begin
                    result_address <= s_reg;
                    result_end     <= e_reg;
                end
                SEL_FOUND:
                begin
                    result_address      <= hit_ent_reg.start_addr;
                    result_end          <= hit_ent_reg.end_addr;
                    result_protection   <= hit_ent_reg.prot;
                    result_region_flags <= hit_ent_reg.flags;
                    result_file_desc    <= hit_ent_reg.fdesc;
                    result_file_offset  <= hit_ent_reg.foffset;
                end
                SEL_RESERVE:
                begin
                    result_address <= s_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.len_zero   = len_zero_reg;
        stat.len_ok     = len_ok_reg;
        stat.carry      = carry_reg;
        stat.base_wrap  = base_wrap_reg;
        stat.e_ge_limit = (e_reg >= USER_LIMIT);
        stat.clash      = clash_reg;
        stat.free_found = free_found_reg;
        stat.found      = found_reg;
        stat.scan_done  = scan_done;
    end

    // A stored region occupies exactly one more slot afterwards.
    a_write_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && cmd.act == ACT_WRITE) |=>
        ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("region write did not fill exactly one slot");

    a_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CNT_W'(REGION_SLOTS))
        else $error("scan index ran past the table");

    // Clear leaves an empty table and the initial mapping base.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && cmd.act == ACT_CLEAR) |=>
        (valid_reg == '0 && mb_reg == BASE_RESET))
        else $error("clear left regions or a moved mapping base behind");

endmodule

`default_nettype wire

### sv/vmrt_ctrl.sv
// Controller of the region table: sequences alignment, slot scan and completion,
// and decides status and state change of each command. Uses vmrt_pkg.
`default_nettype none

module vmrt_ctrl
    import vmrt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    input  wire dp_stat_t stat,
    output ctrl_cmd_t     cmd_o
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP1 = 3'd1;
    localparam logic [2:0] ST_PREP2 = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       fin_go;

    status_t fin_status;
    act_t    fin_act;
    sel_t    fin_sel;

    assign fin_go = !out_valid_reg || !out_stall;

    // Outcome of the command from the alignment and scan results.
    always_comb
    begin
        fin_status = ST_REJECTED;
        fin_act    = ACT_NONE;
        fin_sel    = SEL_NONE;
        case (stat.cmd)
            CMD_ADD:
            begin
                if (stat.len_zero || !stat.len_ok || stat.carry || stat.clash)
                begin
                    fin_status = ST_REJECTED;
                end
                else if (!stat.free_found)
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    fin_status = ST_OK;
                    fin_act    = ACT_WRITE;
                    fin_sel    = SEL_ADD;
                end
            end
            CMD_FIND:
            begin
                if (stat.found)
                begin
                    fin_status = ST_OK;
                    fin_sel    = SEL_FOUND;
                end
                else
                begin
                    fin_status = ST_NOT_FOUND;
                end
            end
            CMD_REMOVE:
            begin
                if (stat.len_zero)
                begin
                    fin_status = ST_REJECTED;
                end
                else if (stat.found)
                begin
                    fin_status = ST_OK;
                    fin_act    = ACT_REMOVE;
                end
                else
                begin
                    fin_status = ST_NOT_FOUND;
                end
            end
            CMD_RESERVE:
            begin
                if (!stat.len_ok || stat.base_wrap || stat.carry || stat.e_ge_limit)
                begin
                    fin_status = ST_REJECTED;
                end
                else
                begin
                    fin_status = ST_OK;
                    fin_act    = ACT_BUMP;
                    fin_sel    = SEL_RESERVE;
                end
            end
            CMD_CLEAR:
            begin
                fin_status = ST_OK;
                fin_act    = ACT_CLEAR;
            end
            default:
            begin
                fin_status = ST_REJECTED;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_o      = '0;
        cmd_o.status = fin_status;
        cmd_o.act    = fin_act;
        cmd_o.sel    = fin_sel;
        in_stall   = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_o.load = 1'b1;
                    state_next = ST_PREP1;
                end
            end
            ST_PREP1:
            begin
                cmd_o.prep1 = 1'b1;
                state_next  = ST_PREP2;
            end
            ST_PREP2:
            begin
                cmd_o.prep2     = 1'b1;
                cmd_o.scan_init = 1'b1;
                if (stat.cmd inside {CMD_ADD, CMD_FIND, CMD_REMOVE})
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SCAN:
            begin
                cmd_o.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    cmd_o.finish   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_fin_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && fin_go) |=> out_valid_reg)
        else $error("completed command did not present a result");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_PREP1))
        else $error("accepted word did not start alignment");

    a_write_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_o.finish && cmd_o.act == ACT_WRITE) |-> (stat.free_found && !stat.clash))
        else $error("region stored without a free slot or despite an overlap");

endmodule

`default_nettype wire
